// ===== rtl/mqspq_pkg.sv =====
// Package for the multi-queue stable priority queue.
// Holds sizes, payload structs, status codes and controller types; no dependencies.
package mqspq_pkg;

  localparam int NUM_QUEUES    = 3;
  localparam int QUEUE_DEPTH   = 256;
  localparam int PRIORITY_BITS = 4;
  localparam int TICKET_BITS   = 16;

  localparam int QSEL_W = 2;
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                     func;
    logic [QSEL_W-1:0]        queue_sel;
    logic [PRIORITY_BITS-1:0] priority_req;
  } in_data_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [TICKET_BITS-1:0] ticket;
  } out_data_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TICKET_BITS-1:0]   tick;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT_INIT,
    S_SHIFT,
    S_FINISH,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic set_err;
    logic ins_write;
    logic scan_start;
    logic scan_rd;
    logic shift_init;
    logic shift_rd;
    logic rm_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic bad_q;
    logic is_remove;
    logic full;
    logic empty;
    logic scan_last;
    logic shift_more;
    logic out_free;
  } sts_t;

  function automatic logic [ADDR_W-1:0] mem_addr(logic [QIDX_W-1:0] q,
                                                  logic [IDX_W-1:0] idx);
    logic [ADDR_W+QIDX_W+IDX_W-1:0] a;
    a = (ADDR_W+QIDX_W+IDX_W)'(q) * (ADDR_W+QIDX_W+IDX_W)'(QUEUE_DEPTH)
        + (ADDR_W+QIDX_W+IDX_W)'(idx);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/multi_queue_stable_priority_queue.sv =====
// Top level of the multi-queue stable priority queue.
// Instantiates mqspq_ctrl and mqspq_dp; uses mqspq_pkg.
//
// One transaction is worked at a time. Insert, and any error result, are set up
// in S_DECODE and loaded into the result register in S_RESP. A remove from a queue
// holding n entries scans them through the single read port of the shared
// entry memory, one per cycle, then compacts the entries behind the winner one
// per cycle; S_FINISH and S_RESP then load the result register. The next
// transaction is accepted once the result is loaded, while it still waits.
module multi_queue_stable_priority_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mqspq_pkg::in_data_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mqspq_pkg::out_data_t out_data_o
);

  mqspq_pkg::cmd_t cmd;
  mqspq_pkg::sts_t sts;

  mqspq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  mqspq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/mqspq_ctrl.sv =====
// Controller state machine for the multi-queue stable priority queue.
// Depends on mqspq_pkg; drives commands into mqspq_dp.
module mqspq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mqspq_pkg::sts_t  sts_i,
  output mqspq_pkg::cmd_t  cmd_o,
  output logic             in_stall_o
);

  mqspq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mqspq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mqspq_pkg::S_IDLE: begin
        if (sts_i.in_valid) state_d = mqspq_pkg::S_DECODE;
      end
      mqspq_pkg::S_DECODE: begin
        if (sts_i.bad_q || !sts_i.is_remove || sts_i.empty) begin
          state_d = mqspq_pkg::S_RESP;
        end else begin
          state_d = mqspq_pkg::S_SCAN;
        end
      end
      mqspq_pkg::S_SCAN: begin
        if (sts_i.scan_last) state_d = mqspq_pkg::S_SCAN_END;
      end
      mqspq_pkg::S_SCAN_END:   state_d = mqspq_pkg::S_SHIFT_INIT;
      mqspq_pkg::S_SHIFT_INIT: state_d = mqspq_pkg::S_SHIFT;
      mqspq_pkg::S_SHIFT: begin
        if (!sts_i.shift_more) state_d = mqspq_pkg::S_FINISH;
      end
      mqspq_pkg::S_FINISH:     state_d = mqspq_pkg::S_RESP;
      mqspq_pkg::S_RESP: begin
        if (sts_i.out_free) state_d = mqspq_pkg::S_IDLE;
      end
      default:                 state_d = mqspq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mqspq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = sts_i.in_valid;
      end
      mqspq_pkg::S_DECODE: begin
        if (sts_i.bad_q || (sts_i.is_remove && sts_i.empty) ||
            (!sts_i.is_remove && sts_i.full)) begin
          cmd_o.set_err = 1'b1;
        end else if (!sts_i.is_remove) begin
          cmd_o.ins_write = 1'b1;
        end else begin
          cmd_o.scan_start = 1'b1;
        end
      end
      mqspq_pkg::S_SCAN:       cmd_o.scan_rd = 1'b1;
      mqspq_pkg::S_SCAN_END:   cmd_o = '0;
      mqspq_pkg::S_SHIFT_INIT: cmd_o.shift_init = 1'b1;
      mqspq_pkg::S_SHIFT:      cmd_o.shift_rd = sts_i.shift_more;
      mqspq_pkg::S_FINISH:     cmd_o.rm_done = 1'b1;
      mqspq_pkg::S_RESP:       cmd_o.out_load = sts_i.out_free;
      default:                 cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/mqspq_dp.sv =====
// Datapath for the multi-queue stable priority queue: entry memory, fill counts,
// ticket counter, best-entry scan, compaction and output register. Uses mqspq_pkg.
module mqspq_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  mqspq_pkg::in_data_t  in_data_i,
  input  mqspq_pkg::cmd_t      cmd_i,
  output mqspq_pkg::sts_t      sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mqspq_pkg::out_data_t out_data_o
);

  localparam int IW = mqspq_pkg::IDX_W;
  localparam int CW = mqspq_pkg::CNT_W;
  localparam int QW = mqspq_pkg::QIDX_W;
  localparam int PW = mqspq_pkg::PRIORITY_BITS;
  localparam int TW = mqspq_pkg::TICKET_BITS;
  localparam int AW = mqspq_pkg::ADDR_W;

  mqspq_pkg::entry_t mem [mqspq_pkg::MEM_DEPTH];
  mqspq_pkg::entry_t rdata_q;

  logic [CW-1:0] cnt_q [mqspq_pkg::NUM_QUEUES];
  logic [TW-1:0] ticket_q;

  mqspq_pkg::in_data_t cmd_q;
  logic [QW-1:0] qidx;
  logic [CW-1:0] n;

  logic [IW-1:0] rd_idx_q, cmp_idx_q, best_idx_q, ptr_q, pend_idx_q;
  logic          rd_v_q, pend_q;
  logic [PW-1:0] best_prio_q;
  logic [TW-1:0] best_tick_q;

  logic [1:0]    res_status_q;
  logic [TW-1:0] res_ticket_q;

  logic                 out_valid_q;
  mqspq_pkg::out_data_t out_q;

  logic [AW-1:0]     rd_addr, wr_addr;
  logic              we;
  mqspq_pkg::entry_t wdata;
  logic [CW-1:0]     ptr_next;

  assign qidx     = QW'(cmd_q.queue_sel);
  assign n        = cnt_q[qidx];
  assign ptr_next = CW'(ptr_q) + CW'(1);

  assign sts_o.in_valid   = in_valid_i;
  assign sts_o.bad_q      = (32'(cmd_q.queue_sel) >= mqspq_pkg::NUM_QUEUES);
  assign sts_o.is_remove  = (cmd_q.func == mqspq_pkg::FUNC_REMOVE);
  assign sts_o.full       = (n >= CW'(mqspq_pkg::QUEUE_DEPTH));
  assign sts_o.empty      = (n == '0);
  assign sts_o.scan_last  = (CW'(rd_idx_q) + CW'(1) >= n);
  assign sts_o.shift_more = (ptr_next < n);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cmd_i.scan_rd) begin
      rd_addr = mqspq_pkg::mem_addr(qidx, rd_idx_q);
    end else begin
      rd_addr = mqspq_pkg::mem_addr(qidx, ptr_next[IW-1:0]);
    end
    if (cmd_i.ins_write) begin
      we      = 1'b1;
      wr_addr = mqspq_pkg::mem_addr(qidx, n[IW-1:0]);
      wdata   = '{prio: cmd_q.priority_req[PW-1:0], tick: ticket_q};
    end else begin
      we      = pend_q;
      wr_addr = mqspq_pkg::mem_addr(qidx, pend_idx_q);
      wdata   = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wdata;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) cmd_q <= in_data_i;
    if (cmd_i.scan_start) rd_idx_q <= '0;
    else if (cmd_i.scan_rd) rd_idx_q <= rd_idx_q + IW'(1);
    cmp_idx_q <= rd_idx_q;
    if (rd_v_q && (cmp_idx_q == '0 || rdata_q.prio > best_prio_q)) begin
      best_idx_q  <= cmp_idx_q;
      best_prio_q <= rdata_q.prio;
      best_tick_q <= rdata_q.tick;
    end
    if (cmd_i.shift_init) ptr_q <= best_idx_q;
    else if (cmd_i.shift_rd) ptr_q <= ptr_next[IW-1:0];
    pend_idx_q <= ptr_q;
    if (cmd_i.set_err) begin
      res_status_q <= sts_o.is_remove ? mqspq_pkg::ST_EMPTY : mqspq_pkg::ST_FULL;
      res_ticket_q <= '0;
    end else if (cmd_i.ins_write) begin
      res_status_q <= mqspq_pkg::ST_OK;
      res_ticket_q <= ticket_q;
    end else if (cmd_i.rm_done) begin
      res_status_q <= mqspq_pkg::ST_OK;
      res_ticket_q <= best_tick_q;
    end
    if (cmd_i.out_load) out_q <= '{status: res_status_q, ticket: res_ticket_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      pend_q      <= 1'b0;
      ticket_q    <= TW'(1);
      out_valid_q <= 1'b0;
      for (int i = 0; i < mqspq_pkg::NUM_QUEUES; i++) cnt_q[i] <= '0;
    end else begin
      rd_v_q <= cmd_i.scan_rd;
      pend_q <= cmd_i.shift_rd;
      if (cmd_i.ins_write) begin
        cnt_q[qidx] <= n + CW'(1);
        ticket_q    <= ticket_q + TW'(1);
      end else if (cmd_i.rm_done) begin
        cnt_q[qidx] <= n - CW'(1);
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sv/tb_multi_queue_stable_priority_queue.sv =====
// Testbench for multi_queue_stable_priority_queue: directed table, then random
// insert/remove traffic checked against an in-bench priority queue predictor.
// Depends on mqspq_pkg and the RTL top only.
module tb_multi_queue_stable_priority_queue;

  typedef struct {
    logic                 func;
    logic [1:0]           qsel;
    logic [3:0]           prio;
    logic                 chk;
    mqspq_pkg::status_e   st;
    logic [15:0]          tk;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  mqspq_pkg::in_data_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  mqspq_pkg::out_data_t out_data_o;

  multi_queue_stable_priority_queue dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #2 clk_i = ~clk_i;

  mqspq_pkg::entry_t    pq_entries[mqspq_pkg::NUM_QUEUES][$];
  logic [15:0]          pq_ticket;
  mqspq_pkg::out_data_t exp_results[$];
  logic                 exp_fixed[$];
  mqspq_pkg::out_data_t fixed_results[$];
  int                   errors = 0;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  bit                   hold_rx = 1'b0;
  int                   quiet = 0;

  function automatic mqspq_pkg::out_data_t pq_apply(mqspq_pkg::in_data_t d);
    mqspq_pkg::out_data_t r;
    int best;
    int q;
    r = '0;
    q = int'(d.queue_sel);
    if (q >= mqspq_pkg::NUM_QUEUES) begin
      r.status = (d.func == mqspq_pkg::FUNC_REMOVE) ? mqspq_pkg::ST_EMPTY
                                                    : mqspq_pkg::ST_FULL;
    end else if (d.func == mqspq_pkg::FUNC_INSERT) begin
      if (pq_entries[q].size() >= mqspq_pkg::QUEUE_DEPTH) begin
        r.status = mqspq_pkg::ST_FULL;
      end else begin
        pq_entries[q].push_back('{prio: d.priority_req, tick: pq_ticket});
        r.status = mqspq_pkg::ST_OK;
        r.ticket = pq_ticket;
        pq_ticket = pq_ticket + 16'd1;
      end
    end else if (pq_entries[q].size() == 0) begin
      r.status = mqspq_pkg::ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < pq_entries[q].size(); i++)
        if (pq_entries[q][i].prio > pq_entries[q][best].prio) best = i;
      r.status = mqspq_pkg::ST_OK;
      r.ticket = pq_entries[q][best].tick;
      pq_entries[q].delete(best);
    end
    return r;
  endfunction

  task automatic send_op(logic f, logic [1:0] qs, logic [3:0] p, logic chk = 1'b0,
                         mqspq_pkg::status_e st = mqspq_pkg::ST_OK,
                         logic [15:0] tk = '0);
    mqspq_pkg::in_data_t d;
    mqspq_pkg::out_data_t r;
    d.func = f;
    d.queue_sel = qs;
    d.priority_req = p;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_data_i <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = pq_apply(d);
    exp_results.push_back(r);
    exp_fixed.push_back(chk);
    fixed_results.push_back('{status: st, ticket: tk});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    mqspq_pkg::out_data_t e;
    if (out_valid_o && !out_stall_i) begin
      if (exp_results.size() == 0) begin
        $error("unexpected result status=%0d ticket=%0d", out_data_o.status,
               out_data_o.ticket);
        errors++;
      end else begin
        e = exp_results.pop_front();
        if (exp_fixed.pop_front()) e = fixed_results[0];
        void'(fixed_results.pop_front());
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.ticket !== e.ticket) begin
          $error("ticket: expected %0d, got %0d", e.ticket, out_data_o.ticket);
          errors++;
        end
      end
    end
    out_stall_i <= hold_rx || (stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 50000) begin
      $display("tb_multi_queue_stable_priority_queue: done, errors");
      $finish;
    end
  end

  row_t dir_rows[16] = '{
    '{mqspq_pkg::FUNC_REMOVE, 2'd0, 4'd0,  1'b1, mqspq_pkg::ST_EMPTY, 16'd0},
    '{mqspq_pkg::FUNC_INSERT, 2'd0, 4'd0,  1'b1, mqspq_pkg::ST_OK,    16'd1},
    '{mqspq_pkg::FUNC_INSERT, 2'd0, 4'd15, 1'b1, mqspq_pkg::ST_OK,    16'd2},
    '{mqspq_pkg::FUNC_INSERT, 2'd0, 4'd15, 1'b1, mqspq_pkg::ST_OK,    16'd3},
    '{mqspq_pkg::FUNC_INSERT, 2'd0, 4'd7,  1'b0, mqspq_pkg::ST_OK,    16'd0},
    '{mqspq_pkg::FUNC_INSERT, 2'd3, 4'd5,  1'b1, mqspq_pkg::ST_FULL,  16'd0},
    '{mqspq_pkg::FUNC_REMOVE, 2'd3, 4'd0,  1'b1, mqspq_pkg::ST_EMPTY, 16'd0},
    '{mqspq_pkg::FUNC_REMOVE, 2'd0, 4'd9,  1'b1, mqspq_pkg::ST_OK,    16'd2},
    '{mqspq_pkg::FUNC_REMOVE, 2'd0, 4'd0,  1'b1, mqspq_pkg::ST_OK,    16'd3},
    '{mqspq_pkg::FUNC_INSERT, 2'd1, 4'd10, 1'b0, mqspq_pkg::ST_OK,    16'd0},
    '{mqspq_pkg::FUNC_INSERT, 2'd2, 4'd10, 1'b0, mqspq_pkg::ST_OK,    16'd0},
    '{mqspq_pkg::FUNC_REMOVE, 2'd0, 4'd0,  1'b0, mqspq_pkg::ST_OK,    16'd0},
    '{mqspq_pkg::FUNC_REMOVE, 2'd0, 4'd0,  1'b0, mqspq_pkg::ST_OK,    16'd0},
    '{mqspq_pkg::FUNC_REMOVE, 2'd0, 4'd0,  1'b1, mqspq_pkg::ST_EMPTY, 16'd0},
    '{mqspq_pkg::FUNC_REMOVE, 2'd2, 4'd15, 1'b0, mqspq_pkg::ST_OK,    16'd0},
    '{mqspq_pkg::FUNC_REMOVE, 2'd1, 4'd0,  1'b0, mqspq_pkg::ST_OK,    16'd0}
  };

  task automatic rand_phase(int n);
    int q;
    for (int i = 0; i < n; i++) begin
      q = ($urandom_range(19) == 0) ? 3 : $urandom_range(mqspq_pkg::NUM_QUEUES - 1);
      send_op(($urandom_range(99) < 55) ? mqspq_pkg::FUNC_INSERT : mqspq_pkg::FUNC_REMOVE,
              q[1:0], 4'($urandom));
    end
  endtask

  initial begin
    pq_ticket = 16'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i])
      send_op(dir_rows[i].func, dir_rows[i].qsel, dir_rows[i].prio, dir_rows[i].chk,
              dir_rows[i].st, dir_rows[i].tk);
    drain();
    rand_phase(100);
    idle_pct = 53;
    rand_phase(100);
    idle_pct = 0;
    stall_pct = 53;
    rand_phase(100);
    idle_pct = 18;
    stall_pct = 18;
    rand_phase(100);
    drain();
    // long receiver hold-off while the sender keeps offering
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      rand_phase(20);
    join
    drain();
    // fill queue 1 to capacity, overflow it, then empty it past the bottom
    for (int i = 0; i < mqspq_pkg::QUEUE_DEPTH + 3; i++)
      send_op(mqspq_pkg::FUNC_INSERT, 2'd1, 4'($urandom));
    for (int i = 0; i < 20; i++) send_op(mqspq_pkg::FUNC_REMOVE, 2'd1, 4'd0);
    stall_pct = 18;
    for (int i = 0; i < mqspq_pkg::QUEUE_DEPTH - 15; i++)
      send_op(mqspq_pkg::FUNC_REMOVE, 2'd1, 4'($urandom));
    stall_pct = 0;
    drain();
    rand_phase(100);
    drain();
    repeat (600) @(posedge clk_i);
    if (errors == 0) $display("tb_multi_queue_stable_priority_queue: done, clean");
    else $display("tb_multi_queue_stable_priority_queue: done, errors");
    $finish;
  end
endmodule

// ===== multi_queue_stable_priority_queue.f =====
rtl/mqspq_pkg.sv
rtl/mqspq_ctrl.sv
rtl/mqspq_dp.sv
rtl/multi_queue_stable_priority_queue.sv
tb/sv/tb_multi_queue_stable_priority_queue.sv
